@@ hdl/mcos_pkg.sv @@
// Package with the shared types and constants of the motor command and odometry block.
`default_nettype none

package mcos_pkg;

   // Event codes carried in the op field of a request word.
   typedef enum logic [2:0] {
      OP_ENCODER  = 3'd0,
      OP_SETPOINT = 3'd1,
      OP_ENABLE   = 3'd2,
      OP_DISABLE  = 3'd3,
      OP_ODO_CLR  = 3'd4,
      OP_SPIN     = 3'd5,
      OP_FWDBACK  = 3'd6,
      OP_TICK     = 3'd7
   } op_type;

   typedef logic signed [15:0] speed_type;
   typedef logic signed [31:0] dist_type;

   // Drive command and flags that the sweep controller hands over for one tick.
   typedef struct packed {
      speed_type left_drive;
      speed_type right_drive;
      logic      motors_on;
      logic      sweep_running;
   } tick_status_type;

   localparam speed_type SPIN_LEFT_START    = 16'sd300;
   localparam speed_type SPIN_RIGHT_START   = -16'sd300;
   localparam speed_type SPIN_LEFT_FLOOR    = -16'sd300;
   localparam speed_type FWDBACK_START      = -16'sd150;
   localparam logic [15:0] STEP_TICKS_RESET = 16'd250;
   localparam logic [15:0] TICKS_MAX        = 16'hFFFF;

endpackage

`default_nettype wire

@@ hdl/mcos_channels.sv @@
// Handshake interfaces for the request, response and register write channels.
`default_nettype none

interface mcos_req_if;
   logic                valid;
   logic                ready;
   mcos_pkg::op_type    op;
   mcos_pkg::speed_type left_value;
   mcos_pkg::speed_type right_value;

   modport source(output valid, output op, output left_value, output right_value, input ready);
   modport sink(input valid, input op, input left_value, input right_value, output ready);
endinterface

interface mcos_rsp_if;
   logic                valid;
   logic                ready;
   mcos_pkg::speed_type left_drive;
   mcos_pkg::speed_type right_drive;
   mcos_pkg::speed_type left_step;
   mcos_pkg::speed_type right_step;
   mcos_pkg::dist_type  left_distance;
   mcos_pkg::dist_type  right_distance;
   logic                motors_on;
   logic                sweep_running;

   modport source(output valid, output left_drive, output right_drive, output left_step,
                  output right_step, output left_distance, output right_distance,
                  output motors_on, output sweep_running, input ready);
   modport sink(input valid, input left_drive, input right_drive, input left_step,
                input right_step, input left_distance, input right_distance,
                input motors_on, input sweep_running, output ready);
endinterface

interface mcos_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;

   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/mcos_odometry.sv @@
// Encoder baseline, wrapping deltas and the two 32-bit odometers.
`default_nettype none

module mcos_odometry (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                fire,
   input  wire mcos_pkg::op_type    op,
   input  wire mcos_pkg::speed_type left_value,
   input  wire mcos_pkg::speed_type right_value,
   output mcos_pkg::speed_type      left_step,
   output mcos_pkg::speed_type      right_step,
   output mcos_pkg::dist_type       left_distance,
   output mcos_pkg::dist_type       right_distance
);
   import mcos_pkg::*;

   speed_type prev_left_ff, prev_left_in, prev_right_ff, prev_right_in;
   speed_type delta_left_ff, delta_left_in, delta_right_ff, delta_right_in;
   dist_type  odo_left_ff, odo_left_in, odo_right_ff, odo_right_in;
   logic      seeded_ff, seeded_in;
   speed_type diff_left, diff_right;

   assign diff_left  = left_value - prev_left_ff;
   assign diff_right = right_value - prev_right_ff;

   always_comb begin
      prev_left_in   = prev_left_ff;
      prev_right_in  = prev_right_ff;
      delta_left_in  = delta_left_ff;
      delta_right_in = delta_right_ff;
      odo_left_in    = odo_left_ff;
      odo_right_in   = odo_right_ff;
      seeded_in      = seeded_ff;
      case (op)
         OP_ENCODER: begin
            // The first reading after reset only sets the baseline.
            if (seeded_ff) begin
               delta_left_in  = diff_left;
               delta_right_in = diff_right;
               odo_left_in    = odo_left_ff + dist_type'(diff_left);
               odo_right_in   = odo_right_ff + dist_type'(diff_right);
            end
            seeded_in     = 1'b1;
            prev_left_in  = left_value;
            prev_right_in = right_value;
         end
         OP_ODO_CLR: begin
            odo_left_in  = '0;
            odo_right_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_left_ff   <= '0;
         prev_right_ff  <= '0;
         delta_left_ff  <= '0;
         delta_right_ff <= '0;
         odo_left_ff    <= '0;
         odo_right_ff   <= '0;
         seeded_ff      <= 1'b0;
      end else if (fire) begin
         prev_left_ff   <= prev_left_in;
         prev_right_ff  <= prev_right_in;
         delta_left_ff  <= delta_left_in;
         delta_right_ff <= delta_right_in;
         odo_left_ff    <= odo_left_in;
         odo_right_ff   <= odo_right_in;
         seeded_ff      <= seeded_in;
      end
   end

   assign left_step      = delta_left_ff;
   assign right_step     = delta_right_ff;
   assign left_distance  = odo_left_ff;
   assign right_distance = odo_right_ff;

endmodule

`default_nettype wire

@@ hdl/mcos_sweep.sv @@
// Drive command, motor enable, speed sweeps and the tick counter between sweep steps.
`default_nettype none

module mcos_sweep (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                fire,
   input  wire mcos_pkg::op_type    op,
   input  wire mcos_pkg::speed_type left_value,
   input  wire mcos_pkg::speed_type right_value,
   input  wire logic [15:0]         step_ticks,
   output mcos_pkg::tick_status_type status
);
   import mcos_pkg::*;

   speed_type   cmd_left_ff, cmd_left_in, cmd_right_ff, cmd_right_in;
   speed_type   sw_left_ff, sw_left_in, sw_right_ff, sw_right_in;
   logic        enable_ff, enable_in, spin_ff, spin_in, fwdback_ff, fwdback_in;
   logic [15:0] ticks_ff, ticks_in;

   logic        active;
   logic        enable_eff;
   speed_type   cmd_left_eff, cmd_right_eff;
   logic [15:0] ticks_inc;
   logic        do_step;
   speed_type   spin_left, spin_right, fb_left, fb_right;

   // A running sweep takes over the command and holds the motors on.
   assign active        = spin_ff | fwdback_ff;
   assign enable_eff    = enable_ff | active;
   assign cmd_left_eff  = active ? sw_left_ff : cmd_left_ff;
   assign cmd_right_eff = active ? sw_right_ff : cmd_right_ff;
   assign ticks_inc     = (ticks_ff == TICKS_MAX) ? ticks_ff : ticks_ff + 16'd1;
   assign do_step       = active && (ticks_inc > step_ticks);

   assign spin_left  = sw_left_ff - 16'sd1;
   assign spin_right = sw_right_ff + 16'sd1;
   assign fb_left    = (sw_left_ff > 16'sd0) ? -(sw_left_ff - 16'sd1) : -sw_left_ff;
   assign fb_right   = (sw_left_ff > 16'sd0) ? -(sw_right_ff - 16'sd1) : -sw_right_ff;

   always_comb begin
      cmd_left_in  = cmd_left_ff;
      cmd_right_in = cmd_right_ff;
      sw_left_in   = sw_left_ff;
      sw_right_in  = sw_right_ff;
      enable_in    = enable_ff;
      spin_in      = spin_ff;
      fwdback_in   = fwdback_ff;
      ticks_in     = ticks_ff;
      case (op)
         OP_SETPOINT: begin
            cmd_left_in  = left_value;
            cmd_right_in = right_value;
         end
         OP_ENABLE: begin
            cmd_left_in  = left_value;
            cmd_right_in = right_value;
            enable_in    = 1'b1;
         end
         OP_DISABLE: begin
            enable_in = 1'b0;
         end
         OP_SPIN: begin
            spin_in     = 1'b1;
            enable_in   = 1'b1;
            sw_left_in  = SPIN_LEFT_START;
            sw_right_in = SPIN_RIGHT_START;
         end
         OP_FWDBACK: begin
            fwdback_in  = 1'b1;
            enable_in   = 1'b1;
            sw_left_in  = FWDBACK_START;
            sw_right_in = FWDBACK_START;
         end
         OP_TICK: begin
            cmd_left_in  = cmd_left_eff;
            cmd_right_in = cmd_right_eff;
            enable_in    = enable_eff;
            ticks_in     = do_step ? 16'd0 : ticks_inc;
            if (do_step) begin
               if (spin_ff) begin
                  // The spin sweep takes precedence when both are running.
                  if (spin_left < SPIN_LEFT_FLOOR) begin
                     sw_left_in   = '0;
                     sw_right_in  = '0;
                     spin_in      = 1'b0;
                     enable_in    = 1'b0;
                     cmd_left_in  = '0;
                     cmd_right_in = '0;
                  end else begin
                     sw_left_in  = spin_left;
                     sw_right_in = spin_right;
                  end
               end else begin
                  sw_left_in  = fb_left;
                  sw_right_in = fb_right;
                  if (fb_left == 16'sd0) begin
                     fwdback_in   = 1'b0;
                     enable_in    = 1'b0;
                     cmd_left_in  = '0;
                     cmd_right_in = '0;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_left_ff  <= '0;
         cmd_right_ff <= '0;
         sw_left_ff   <= '0;
         sw_right_ff  <= '0;
         enable_ff    <= 1'b0;
         spin_ff      <= 1'b0;
         fwdback_ff   <= 1'b0;
         ticks_ff     <= '0;
      end else if (fire) begin
         cmd_left_ff  <= cmd_left_in;
         cmd_right_ff <= cmd_right_in;
         sw_left_ff   <= sw_left_in;
         sw_right_ff  <= sw_right_in;
         enable_ff    <= enable_in;
         spin_ff      <= spin_in;
         fwdback_ff   <= fwdback_in;
         ticks_ff     <= ticks_in;
      end
   end

   // Drive is taken before the step, the flags after it.
   assign status.left_drive    = enable_eff ? cmd_left_eff : '0;
   assign status.right_drive   = enable_eff ? cmd_right_eff : '0;
   assign status.motors_on     = enable_in;
   assign status.sweep_running = spin_in | fwdback_in;

endmodule

`default_nettype wire

@@ hdl/motor_command_odometry_sweep_core.sv @@
// Top level of the two-wheel motor command, odometry and speed sweep block.
//
// Usage: every request word on req_chan carries one event (encoder reading, setpoint,
// enable, disable, odometry clear, spin sweep start, forward/backward sweep start or
// tick) with two 16-bit values. Only a tick produces a response word on rsp_chan; it
// holds the gated drive command, the latest encoder deltas, both odometers and the
// motor and sweep flags. The csr_chan port writes the sweep step interval in ticks; it
// is always ready and should be written only while the block is idle.
//
// Flow: a request word is captured in an input register; once the response register is
// free or being emptied, the event logic updates the state from it and, for a tick, loads
// the response register that drives rsp_chan. One word is taken in every cycle while the
// receiver keeps up; the rate is set by the single state update per cycle.
//
// Reset clears the odometry and sweep state, sets the interval to 250 ticks and drops
// both valids. When the receiver stalls, the response register holds its word, the input
// register holds the next one, and req_chan.ready falls until the response is taken.
`default_nettype none

module motor_command_odometry_sweep_core (
   input  wire logic clock,
   input  wire logic reset,
   mcos_req_if.sink  req_chan,
   mcos_rsp_if.source rsp_chan,
   mcos_csr_if.sink  csr_chan
);
   import mcos_pkg::*;

   // Sweep step interval register.
   logic [15:0] step_ticks_ff;

   // Input register.
   logic      in_valid_ff, in_valid_in;
   op_type    in_op_ff;
   speed_type in_left_ff, in_right_ff;

   // Response register.
   logic            out_valid_ff, out_valid_in;
   speed_type       out_lstep_ff, out_rstep_ff;
   dist_type        out_ldist_ff, out_rdist_ff;
   tick_status_type out_status_ff;

   logic            fire;
   logic            req_take;
   speed_type       odo_lstep, odo_rstep;
   dist_type        odo_ldist, odo_rdist;
   tick_status_type tick_status;

   // The held word moves on whenever the response register is free or being emptied.
   assign fire     = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !in_valid_ff || fire;
   assign csr_chan.ready = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (fire && (in_op_ff == OP_TICK)) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ticks_ff <= STEP_TICKS_RESET;
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_chan.valid) begin
            step_ticks_ff <= csr_chan.data;
         end
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff    <= req_chan.op;
         in_left_ff  <= req_chan.left_value;
         in_right_ff <= req_chan.right_value;
      end
   end

   // A tick leaves the odometry untouched, so its current values are the ones reported.
   always_ff @(posedge clock) begin
      if (fire && (in_op_ff == OP_TICK)) begin
         out_lstep_ff  <= odo_lstep;
         out_rstep_ff  <= odo_rstep;
         out_ldist_ff  <= odo_ldist;
         out_rdist_ff  <= odo_rdist;
         out_status_ff <= tick_status;
      end
   end

   mcos_odometry u_odometry (
      .clock          (clock),
      .reset          (reset),
      .fire           (fire),
      .op             (in_op_ff),
      .left_value     (in_left_ff),
      .right_value    (in_right_ff),
      .left_step      (odo_lstep),
      .right_step     (odo_rstep),
      .left_distance  (odo_ldist),
      .right_distance (odo_rdist)
   );

   mcos_sweep u_sweep (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .op          (in_op_ff),
      .left_value  (in_left_ff),
      .right_value (in_right_ff),
      .step_ticks  (step_ticks_ff),
      .status      (tick_status)
   );

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.left_drive     = out_status_ff.left_drive;
   assign rsp_chan.right_drive    = out_status_ff.right_drive;
   assign rsp_chan.left_step      = out_lstep_ff;
   assign rsp_chan.right_step     = out_rstep_ff;
   assign rsp_chan.left_distance  = out_ldist_ff;
   assign rsp_chan.right_distance = out_rdist_ff;
   assign rsp_chan.motors_on      = out_status_ff.motors_on;
   assign rsp_chan.sweep_running  = out_status_ff.sweep_running;

endmodule

`default_nettype wire

@@ dv/motor_command_odometry_sweep_core_check.sv @@
// Checker that predicts and compares the response words of the motor command block.
module motor_command_odometry_sweep_core_check (
   input  wire logic   clock,
   input  wire logic   reset,
   mcos_req_if         req_mon,
   mcos_rsp_if         rsp_mon,
   mcos_csr_if         csr_mon,
   output int unsigned mismatch_count,
   output int unsigned pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import mcos_pkg::*;

   localparam int unsigned REPORT_LIMIT = 10;

   typedef struct packed {
      speed_type left_drive;
      speed_type right_drive;
      speed_type left_step;
      speed_type right_step;
      dist_type  left_distance;
      dist_type  right_distance;
      logic      motors_on;
      logic      sweep_running;
   } tick_report_type;

   tick_report_type awaited_reports[$];

   // Predicted state of the block.
   logic [15:0] step_interval;
   speed_type   count_l, count_r;
   logic        seeded;
   dist_type    odo_l, odo_r;
   speed_type   delta_l, delta_r;
   speed_type   cmd_l, cmd_r;
   logic        motors_en, spin_on, fb_on;
   speed_type   sweep_l, sweep_r;
   logic [15:0] tick_count;

   int unsigned errors = 0;
   int unsigned reports_seen = 0;

   task automatic clear_model();
      step_interval = 16'd250;
      count_l = '0;
      count_r = '0;
      seeded = 1'b0;
      odo_l = '0;
      odo_r = '0;
      delta_l = '0;
      delta_r = '0;
      cmd_l = '0;
      cmd_r = '0;
      motors_en = 1'b0;
      spin_on = 1'b0;
      fb_on = 1'b0;
      sweep_l = '0;
      sweep_r = '0;
      tick_count = '0;
      awaited_reports.delete();
   endtask

   task automatic stop_drive();
      motors_en = 1'b0;
      cmd_l = '0;
      cmd_r = '0;
   endtask

   // One speed step of whichever sweep is running; spin takes precedence.
   task automatic step_sweep();
      if (spin_on) begin
         sweep_l = sweep_l - 16'sd1;
         sweep_r = sweep_r + 16'sd1;
         if (sweep_l < -16'sd300) begin
            sweep_l = '0;
            sweep_r = '0;
            spin_on = 1'b0;
            stop_drive();
         end
      end else begin
         if (sweep_l > 16'sd0) begin
            sweep_l = -(sweep_l - 16'sd1);
            sweep_r = -(sweep_r - 16'sd1);
         end else begin
            sweep_l = -sweep_l;
            sweep_r = -sweep_r;
         end
         if (sweep_l == 16'sd0) begin
            fb_on = 1'b0;
            stop_drive();
         end
      end
   endtask

   task automatic apply_event(input op_type op, input speed_type lv, input speed_type rv);
      tick_report_type rep;
      case (op)
         OP_ENCODER: begin
            if (seeded) begin
               delta_l = lv - count_l;
               delta_r = rv - count_r;
               odo_l = odo_l + dist_type'(delta_l);
               odo_r = odo_r + dist_type'(delta_r);
            end
            seeded = 1'b1;
            count_l = lv;
            count_r = rv;
         end
         OP_SETPOINT: begin
            cmd_l = lv;
            cmd_r = rv;
         end
         OP_ENABLE: begin
            cmd_l = lv;
            cmd_r = rv;
            motors_en = 1'b1;
         end
         OP_DISABLE: motors_en = 1'b0;
         OP_ODO_CLR: begin
            odo_l = '0;
            odo_r = '0;
         end
         OP_SPIN: begin
            spin_on = 1'b1;
            motors_en = 1'b1;
            sweep_l = 16'sd300;
            sweep_r = -16'sd300;
         end
         OP_FWDBACK: begin
            fb_on = 1'b1;
            motors_en = 1'b1;
            sweep_l = -16'sd150;
            sweep_r = -16'sd150;
         end
         OP_TICK: begin
            if (spin_on || fb_on) begin
               cmd_l = sweep_l;
               cmd_r = sweep_r;
               motors_en = 1'b1;
            end
            rep.left_drive = motors_en ? cmd_l : '0;
            rep.right_drive = motors_en ? cmd_r : '0;
            if (tick_count != 16'hFFFF)
               tick_count = tick_count + 16'd1;
            if ((spin_on || fb_on) && tick_count > step_interval) begin
               tick_count = '0;
               step_sweep();
            end
            rep.left_step = delta_l;
            rep.right_step = delta_r;
            rep.left_distance = odo_l;
            rep.right_distance = odo_r;
            rep.motors_on = motors_en;
            rep.sweep_running = spin_on || fb_on;
            awaited_reports.push_back(rep);
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         errors++;
         if (errors <= REPORT_LIMIT)
            $display("ERROR: response %0d %s expected %0d got %0d",
                     reports_seen, name, want, got);
      end
   endtask

   task automatic compare_report();
      tick_report_type want;
      if (awaited_reports.size() == 0) begin
         errors++;
         if (errors <= REPORT_LIMIT)
            $display("ERROR: response %0d arrived with none outstanding", reports_seen);
      end else begin
         want = awaited_reports.pop_front();
         check_field("left_drive", want.left_drive, rsp_mon.left_drive);
         check_field("right_drive", want.right_drive, rsp_mon.right_drive);
         check_field("left_step", want.left_step, rsp_mon.left_step);
         check_field("right_step", want.right_step, rsp_mon.right_step);
         check_field("left_distance", want.left_distance, rsp_mon.left_distance);
         check_field("right_distance", want.right_distance, rsp_mon.right_distance);
         check_field("motors_on", want.motors_on, rsp_mon.motors_on);
         check_field("sweep_running", want.sweep_running, rsp_mon.sweep_running);
      end
      reports_seen++;
   endtask

   // Responses are retired before new requests are predicted; a tick never answers
   // at the edge where it is taken.
   always @(posedge clock) begin
      if (reset) begin
         clear_model();
      end else begin
         if (csr_mon.valid && csr_mon.ready)
            step_interval = csr_mon.data;
         if (rsp_mon.valid && rsp_mon.ready)
            compare_report();
         if (req_mon.valid && req_mon.ready)
            apply_event(req_mon.op, req_mon.left_value, req_mon.right_value);
      end
      pending_count <= awaited_reports.size();
      mismatch_count <= errors;
   end

endmodule

@@ dv/motor_command_odometry_sweep_core_tb.sv @@
// Testbench top that drives the motor command block and reports the verdict.
module motor_command_odometry_sweep_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mcos_pkg::*;

   localparam realtime     CLOCK_PERIOD  = 12ns;
   localparam int unsigned RESET_CYCLES  = 7;
   localparam int unsigned CYCLE_LIMIT   = 500000;
   localparam int unsigned HOLD_CYCLES   = 200;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned LONG_RUN      = 100;
   localparam speed_type   MAX_S         = 16'sh7FFF;
   localparam speed_type   MIN_S         = 16'sh8000;

   // How a sweep segment is started: spin alone, forward/backward alone, or spin
   // followed by forward/backward so that both run together.
   typedef enum logic [1:0] {
      SWEEP_SPIN,
      SWEEP_FWDBACK,
      SWEEP_BOTH
   } sweep_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mcos_req_if req_bus();
   mcos_rsp_if rsp_bus();
   mcos_csr_if csr_bus();

   int unsigned mismatch_count;
   int unsigned pending_count;

   // Idle percentages, changed between phases by the stimulus process.
   int unsigned send_gap_pct = 0;
   int unsigned recv_stall_pct = 0;
   // Each increment asks the receiver for one long hold-off.
   int unsigned hold_request = 0;

   int unsigned items_sent = 0;
   speed_type   enc_l = '0;
   speed_type   enc_r = '0;
   int unsigned cycle_count = 0;

   always #(CLOCK_PERIOD / 2.0) clock = ~clock;

   motor_command_odometry_sweep_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   motor_command_odometry_sweep_core_check report_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_mon        (csr_bus),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // Mostly random 16-bit values, with the extremes and zero mixed in often.
   function automatic speed_type pick_value();
      case ($urandom_range(9))
         0: return MAX_S;
         1: return MIN_S;
         2: return 16'sh0000;
         default: return speed_type'($urandom);
      endcase
   endfunction

   // Offers one request word, possibly after a random gap, and returns once the
   // block has taken it. Valid stays high so back-to-back words need no bubble.
   task automatic send_word(input op_type op, input speed_type lv, input speed_type rv);
      while ($urandom_range(99) < send_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.op <= op;
      req_bus.left_value <= lv;
      req_bus.right_value <= rv;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      items_sent++;
   endtask

   // Encoder readings mostly walk by small amounts like a real wheel, so deltas stay
   // plausible; now and then the count jumps anywhere to exercise the wrap.
   task automatic send_encoder();
      if ($urandom_range(9) < 7) begin
         enc_l = enc_l + speed_type'($urandom_range(400) - 200);
         enc_r = enc_r + speed_type'($urandom_range(400) - 200);
      end else begin
         enc_l = speed_type'($urandom);
         enc_r = speed_type'($urandom);
      end
      send_word(OP_ENCODER, enc_l, enc_r);
   endtask

   task automatic send_any();
      op_type op;
      op = op_type'($urandom_range(7));
      if (op == OP_ENCODER)
         send_encoder();
      else
         send_word(op, pick_value(), pick_value());
   endtask

   // A well-formed sweep: start it, then mostly ticks, with encoder readings and the
   // odd command or disable in between that the sweep should override.
   task automatic run_sweep(input sweep_kind_type kind, input int unsigned n_ticks);
      if (kind != SWEEP_FWDBACK)
         send_word(OP_SPIN, pick_value(), pick_value());
      if (kind != SWEEP_SPIN)
         send_word(OP_FWDBACK, pick_value(), pick_value());
      repeat (n_ticks) begin
         if ($urandom_range(99) < 20) begin
            case ($urandom_range(3))
               0, 1: send_encoder();
               2: send_word(OP_SETPOINT, pick_value(), pick_value());
               default: send_word(OP_DISABLE, pick_value(), pick_value());
            endcase
         end
         send_word(OP_TICK, pick_value(), pick_value());
      end
   endtask

   // Mostly sweep segments of random length, the rest bursts of arbitrary words.
   task automatic random_phase(input int unsigned n_items);
      int unsigned stop_at;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         if ($urandom_range(99) < 60)
            run_sweep(sweep_kind_type'($urandom_range(2)), $urandom_range(60, 5));
         else
            repeat ($urandom_range(30, 5)) send_any();
      end
   endtask

   // Stops offering words and waits until every predicted response has been taken.
   // The extra cycles let a trailing word that makes no response finish as well.
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_interval(input logic [15:0] ticks);
      csr_bus.valid <= 1'b1;
      csr_bus.data <= ticks;
      @(posedge clock);
      while (!csr_bus.ready)
         @(posedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic set_idle(input int unsigned send_pct, input int unsigned recv_pct);
      send_gap_pct <= send_pct;
      recv_stall_pct <= recv_pct;
   endtask

   // Receiver side. It stalls at random, and when asked it holds ready low for a
   // long stretch so that the response and input registers both fill and the
   // block has to refuse new words.
   initial begin
      int unsigned hold_left;
      int unsigned hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold_left != 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (hold_seen != hold_request) begin
            hold_seen = hold_request;
            hold_left = HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin
      req_bus.valid <= 1'b0;
      req_bus.op <= OP_TICK;
      req_bus.left_value <= '0;
      req_bus.right_value <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.data <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset interval of 250 ticks, so no sweep step yet.
      // The sender idles a little and the receiver a lot.
      set_idle(13, 57);
      send_word(OP_TICK, 16'sh0000, 16'sh0000);
      // The first reading only seeds the baseline; the tick after it must still
      // show zero deltas.
      send_word(OP_ENCODER, MAX_S, MIN_S);
      send_word(OP_TICK, -16'sd1, 16'sd1);
      // Readings that wrap give deltas of +1 and -1, then deltas of -32768 and -32767.
      send_word(OP_ENCODER, MIN_S, MAX_S);
      send_word(OP_ENCODER, 16'sh0000, 16'sh0000);
      send_word(OP_TICK, MAX_S, MAX_S);
      // A setpoint alone leaves the motors off, so the drive reads zero.
      send_word(OP_SETPOINT, MAX_S, MIN_S);
      send_word(OP_TICK, MIN_S, MIN_S);
      send_word(OP_ENABLE, MIN_S, MAX_S);
      send_word(OP_TICK, 16'sh0000, -16'sd1);
      send_word(OP_DISABLE, -16'sd1, -16'sd1);
      send_word(OP_TICK, 16'sh5555, 16'shAAAA);
      send_word(OP_ODO_CLR, 16'shAAAA, 16'sh5555);
      send_word(OP_TICK, 16'sh0000, 16'sh0000);
      send_word(OP_SPIN, MAX_S, MIN_S);
      send_word(OP_TICK, 16'sh0000, 16'sh0000);
      // Starting forward/backward on top of spin leaves both sweeps running.
      send_word(OP_FWDBACK, MIN_S, MAX_S);
      send_word(OP_TICK, 16'sh0000, 16'sh0000);
      // A running sweep overrides an enable command and a disable.
      send_word(OP_ENABLE, 16'sd1, -16'sd1);
      send_word(OP_DISABLE, 16'sh0000, 16'sh0000);
      send_word(OP_TICK, 16'sh0000, 16'sh0000);
      send_word(OP_ENCODER, -16'sd1, -16'sd1);
      send_word(OP_TICK, 16'sh0000, 16'sh0000);
      drain();

      // An interval of one tick: a step every second tick. The receiver is told to hold
      // off for a long stretch while random words keep coming.
      write_interval(16'd1);
      hold_request <= hold_request + 1;
      random_phase(200);
      // Both sweeps run together; the spin steps while forward/backward stays set.
      run_sweep(SWEEP_BOTH, 150);
      drain();

      // The receiver now idles a little and the sender a lot.
      set_idle(57, 13);
      write_interval(16'($urandom_range(40, 2)));
      random_phase(250);
      drain();

      // No idling from here on. At the largest interval a step never comes, however
      // long the sweep runs.
      set_idle(0, 0);
      write_interval(16'hFFFF);
      send_word(OP_SPIN, pick_value(), pick_value());
      repeat (LONG_RUN) send_word(OP_TICK, pick_value(), pick_value());
      drain();

      // With the count well above it, a short interval makes the very next tick step.
      write_interval(16'd5);
      send_word(OP_FWDBACK, pick_value(), pick_value());
      random_phase(120);
      drain();

      write_interval(16'd250);
      random_phase(80);
      drain();

      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
